// ===== src/vsf_pkg.sv =====
// vsf_pkg: op codes, sequencer states and shared types of the voxel shape fill engine
// no dependencies
package vsf_pkg;

  typedef enum logic [3:0] {
    OP_SET_VOX   = 4'd0,
    OP_CLR_VOX   = 4'd1,
    OP_SET_BOX   = 4'd2,
    OP_CLR_BOX   = 4'd3,
    OP_SET_SPH   = 4'd4,
    OP_CLR_SPH   = 4'd5,
    OP_SET_ELL   = 4'd6,
    OP_CLR_ELL   = 4'd7,
    OP_READ      = 4'd8
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRE,
    ST_SCAN,
    ST_RD,
    ST_RD2,
    ST_WB,
    ST_OUT
  } state_t;

  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;
  localparam logic [1:0] REG_ALPHA = 2'd3;

  // one grid walk position (cell indices), used to form the memory address
  typedef struct packed {
    logic       ellip;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] dz;
  } tst_t;

endpackage

// ===== src/vsf_mul.sv =====
// vsf_mul: shared registered multiplier, 32 x 32 bits
// depends on nothing
module vsf_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  logic [63:0] p_r;
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
  assign p = p_r;
endmodule

// ===== src/voxel_shape_fill_engine.sv =====
// voxel_shape_fill_engine: voxel grid with single voxel, box, sphere and ellipsoid set/clear and read
// uses vsf_pkg and the shared multiplier vsf_mul
// a setup pass precedes every operation; a read or single voxel write touches only the
// addressed cell if it lies in the grid, a box walks its clipped volume, a sphere or ellipsoid
// walks the whole grid (the shared multiplier squares and weights each axis in turn); one
// transaction at a time, the next one is taken from the cycle after the result is taken
// reset: synchronous, active low; a clearing pass over all 2^(address bits) cells (the grid
// size for power-of-two sizes) clears occupancy, during which no item is accepted (config taken)
module voxel_shape_fill_engine import vsf_pkg::*; #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic signed [7:0] in_pos_x,
  input  logic signed [7:0] in_pos_y,
  input  logic signed [7:0] in_pos_z,
  input  logic signed [7:0] in_end_x,
  input  logic signed [7:0] in_end_y,
  input  logic signed [7:0] in_end_z,
  input  logic [6:0]  in_rad_x,
  input  logic [6:0]  in_rad_y,
  input  logic [6:0]  in_rad_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_voxel_on,
  output logic [7:0]  out_voxel_red,
  output logic [7:0]  out_voxel_green,
  output logic [7:0]  out_voxel_blue,
  output logic [7:0]  out_voxel_alpha,
  output logic [15:0] out_occupied_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int BX = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int BY = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int BZ = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int AW = BX + BY + BZ;
  localparam int DEPTH = 1 << AW;
  localparam logic [7:0] GXM = 8'(GRID_X - 1);
  localparam logic [7:0] GYM = 8'(GRID_Y - 1);
  localparam logic [7:0] GZM = 8'(GRID_Z - 1);

  // memories: occupancy and colour, each with a write port and a read port
  logic        occ_mem [DEPTH];
  logic [31:0] col_mem [DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic        mem_wocc, mem_wcol;
  logic        occ_rd_r;
  logic [31:0] col_rd_r;
  logic [31:0] paint_w;

  always_ff @(posedge clk) begin
    if (mem_we) occ_mem[mem_wa] <= mem_wocc;
    if (mem_we && mem_wcol) col_mem[mem_wa] <= paint_w;
    occ_rd_r <= occ_mem[mem_ra];
    col_rd_r <= col_mem[mem_ra];
  end

  // config registers
  logic [7:0] red_r, green_r, blue_r, alpha_r;
  assign paint_w = {red_r, green_r, blue_r, alpha_r};
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r <= 8'd0; green_r <= 8'd0; blue_r <= 8'd0; alpha_r <= 8'd255;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RED:   red_r   <= cfg_data;
        REG_GREEN: green_r <= cfg_data;
        REG_BLUE:  blue_r  <= cfg_data;
        REG_ALPHA: alpha_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // sequencer state
  state_t st_r, st_nxt;
  logic [3:0] op_r;
  logic       set_r;
  logic [7:0] px_r, py_r, pz_r;
  logic [7:0] x0_r, y0_r, z0_r, x1_r, y1_r, z1_r;
  logic [7:0] i_r, j_r, k_r;
  logic [AW:0] clr_r;
  logic [18:0] cnt_r;
  logic [6:0] rx_r, ry_r, rz_r;
  logic [31:0] ax_r, ay_r, az_r, wx_r, wy_r, wz_r;
  logic [63:0] lim_r, acc_r;
  logic [4:0] ph_r;
  logic hit_r;
  logic [31:0] m_a, m_b;
  logic [63:0] m_p;
  logic       r_on_r;
  logic [31:0] r_col_r;

  vsf_mul u_mul (.clk(clk), .a(m_a), .b(m_b), .p(m_p));

  // clip a signed coordinate into [0, hi]
  function automatic logic [7:0] clipv(input logic [7:0] v, input logic [7:0] hi);
    if (v[7]) return 8'd0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] absd(input logic [7:0] i, input logic [7:0] c);
    logic signed [9:0] d;
    d = $signed({1'b0, i, 1'b0}) - $signed({{2{c[7]}}, c});
    return 32'(d[9] ? -d : d);
  endfunction

  tst_t tst;
  assign tst.ellip = 1'b1;
  assign tst.dx = i_r;
  assign tst.dy = j_r;
  assign tst.dz = k_r;

  logic [AW-1:0] cell_a;
  assign cell_a = {tst.dx[BX-1:0], tst.dy[BY-1:0], tst.dz[BZ-1:0]};

  logic in_g;
  assign in_g = !px_r[7] && !py_r[7] && !pz_r[7] &&
                px_r <= GXM && py_r <= GYM && pz_r <= GZM;

  logic last_k, last_j, last_i;
  assign last_k = (k_r + 8'd1 >= z1_r);
  assign last_j = (j_r + 8'd1 >= y1_r);
  assign last_i = (i_r + 8'd1 >= x1_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (clr_r == (AW+1)'(DEPTH - 1)) st_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) st_nxt = ST_PRE;
      ST_PRE: begin
        if (ph_r == 5'd15) begin
          if (op_r inside {OP_SET_VOX, OP_CLR_VOX, OP_READ}) st_nxt = in_g ? ST_RD : ST_OUT;
          else if (op_r > OP_READ) st_nxt = ST_OUT;
          else if ((x0_r >= x1_r) || (y0_r >= y1_r) || (z0_r >= z1_r) || !hit_r)
            st_nxt = ST_OUT;
          else st_nxt = ST_SCAN;
        end
      end
      ST_SCAN: if (ph_r == 5'd5) st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_RD2;
      ST_RD2:  st_nxt = (op_r == OP_READ) ? ST_OUT : ST_WB;
      ST_WB: begin
        if ((op_r inside {OP_SET_VOX, OP_CLR_VOX}) || (last_k && last_j && last_i))
          st_nxt = ST_OUT;
        else st_nxt = (op_r inside {OP_SET_BOX, OP_CLR_BOX}) ? ST_RD : ST_SCAN;
      end
      ST_OUT:  if (!out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  logic inside_w;
  always_comb begin
    in_stall  = (st_r != ST_IDLE);
    out_valid = (st_r == ST_OUT);
    mem_we   = 1'b0;
    mem_wa   = cell_a;
    mem_wocc = 1'b0;
    mem_wcol = 1'b0;
    mem_ra   = cell_a;
    m_a = 32'd0; m_b = 32'd0;
    inside_w = (op_r inside {OP_SET_BOX, OP_CLR_BOX, OP_SET_VOX, OP_CLR_VOX}) ||
               (acc_r <= lim_r);
    case (st_r)
      ST_CLEAR: begin
        mem_we = 1'b1; mem_wa = clr_r[AW-1:0];
      end
      ST_WB: begin
        mem_we = inside_w; mem_wocc = set_r; mem_wcol = set_r;
      end
      default: ;
    endcase
    // multiplier schedule
    if (st_r == ST_PRE) begin
      case (ph_r)
        5'd0: begin m_a = 32'(rx_r); m_b = 32'(rx_r); end
        5'd1: begin m_a = 32'(ry_r); m_b = 32'(ry_r); end
        5'd2: begin m_a = 32'(rz_r); m_b = 32'(rz_r); end
        5'd4: begin m_a = ay_r; m_b = az_r; end
        5'd5: begin m_a = ax_r; m_b = az_r; end
        5'd6: begin m_a = ax_r; m_b = ay_r; end
        5'd8: begin m_a = wz_r; m_b = az_r; end
        default: ;
      endcase
    end else if (st_r == ST_SCAN) begin
      case (ph_r)
        5'd0: begin m_a = absd(i_r, px_r); m_b = absd(i_r, px_r); end
        5'd1: begin m_a = absd(j_r, py_r); m_b = absd(j_r, py_r); end
        5'd2: begin m_a = absd(k_r, pz_r); m_b = absd(k_r, pz_r); end
        5'd3: begin m_a = sq_r[0]; m_b = wx_r; end
        5'd4: begin m_a = sq_r[1]; m_b = wy_r; end
        5'd5: begin m_a = sq_r[2]; m_b = wz_r; end
        default: ;
      endcase
    end
  end

  // squared distances must each be weighted; keep them in a small buffer
  logic [31:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
      cnt_r <= 19'd0;
      ph_r  <= 5'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (st_r == ST_IDLE && in_valid) begin
        op_r  <= in_op;
        set_r <= !in_op[0];
        px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
        rx_r <= in_rad_x;
        ry_r <= (in_op inside {OP_SET_SPH, OP_CLR_SPH}) ? in_rad_x : in_rad_y;
        rz_r <= (in_op inside {OP_SET_SPH, OP_CLR_SPH}) ? in_rad_x : in_rad_z;
        if (in_op inside {OP_SET_BOX, OP_CLR_BOX}) begin
          x0_r <= clipv(in_pos_x, 8'(GRID_X)); x1_r <= clipv(in_end_x, 8'(GRID_X));
          y0_r <= clipv(in_pos_y, 8'(GRID_Y)); y1_r <= clipv(in_end_y, 8'(GRID_Y));
          z0_r <= clipv(in_pos_z, 8'(GRID_Z)); z1_r <= clipv(in_end_z, 8'(GRID_Z));
        end else begin
          x0_r <= 8'd0; x1_r <= 8'(GRID_X);
          y0_r <= 8'd0; y1_r <= 8'(GRID_Y);
          z0_r <= 8'd0; z1_r <= 8'(GRID_Z);
        end
        hit_r <= !(in_op inside {OP_SET_SPH, OP_CLR_SPH, OP_SET_ELL, OP_CLR_ELL}) ||
                 ((in_rad_x != 7'd0) &&
                  ((in_op inside {OP_SET_SPH, OP_CLR_SPH}) ||
                   (in_rad_y != 7'd0 && in_rad_z != 7'd0)));
        ph_r <= 5'd0;
      end
      if (st_r == ST_PRE) begin
        ph_r <= (ph_r == 5'd15) ? 5'd0 : ph_r + 5'd1;
        case (ph_r)
          5'd1: ax_r <= m_p[31:0];
          5'd2: ay_r <= m_p[31:0];
          5'd3: az_r <= m_p[31:0];
          5'd5: wx_r <= m_p[31:0];
          5'd6: wy_r <= m_p[31:0];
          5'd7: wz_r <= m_p[31:0];
          5'd9: lim_r <= m_p;
          default: ;
        endcase
        if (op_r inside {OP_SET_VOX, OP_CLR_VOX, OP_READ}) begin
          i_r <= px_r; j_r <= py_r; k_r <= pz_r;
        end else begin
          i_r <= x0_r; j_r <= y0_r; k_r <= z0_r;
        end
      end
      // squares land from the registered multiplier in the phase after issue, weighted terms are summed as they arrive
      if (st_r == ST_SCAN) begin
        ph_r <= (ph_r == 5'd5) ? 5'd0 : ph_r + 5'd1;
        case (ph_r)
          5'd1: sq_r[0] <= m_p[31:0];
          5'd2: sq_r[1] <= m_p[31:0];
          5'd3: sq_r[2] <= m_p[31:0];
          5'd4: acc_r <= m_p;
          5'd5: acc_r <= acc_r + m_p;
          default: ;
        endcase
      end
      // last weighted term, issued in the final scan phase
      if (st_r == ST_RD) acc_r <= acc_r + m_p;
      if (st_r == ST_RD2) begin
        r_on_r  <= (op_r == OP_READ) && occ_rd_r;
        r_col_r <= ((op_r == OP_READ) && occ_rd_r) ? col_rd_r : 32'd0;
      end
      if (st_r == ST_WB) begin
        if (inside_w) begin
          if (set_r && !occ_rd_r) cnt_r <= cnt_r + 19'd1;
          if (!set_r && occ_rd_r) cnt_r <= cnt_r - 19'd1;
        end
        if (last_k) begin
          k_r <= z0_r;
          if (last_j) begin
            j_r <= y0_r;
            i_r <= i_r + 8'd1;
          end else j_r <= j_r + 8'd1;
        end else k_r <= k_r + 8'd1;
      end
      if (st_r == ST_IDLE) begin
        r_on_r <= 1'b0; r_col_r <= 32'd0;
      end
    end
  end

  assign out_voxel_on       = r_on_r;
  assign out_voxel_red      = r_col_r[31:24];
  assign out_voxel_green    = r_col_r[23:16];
  assign out_voxel_blue     = r_col_r[15:8];
  assign out_voxel_alpha    = r_col_r[7:0];
  // true count is kept wide, the reported count saturates
  assign out_occupied_count = (cnt_r > 19'h0FFFF) ? 16'hFFFF : cnt_r[15:0];
endmodule
